// ----- rtl/core/cbor_pkg.sv -----
// cbor_pkg: shared types and constants for the CBOR stream decoder.
// Used by cbor_parse, cbor_outreg and cbor_stream_decoder; no dependencies.
package cbor_pkg;

  typedef enum logic [1:0] {
    PH_TYPE    = 2'd0,
    PH_ARG     = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_ERROR   = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    EV_UINT    = 4'd0,
    EV_NEGINT  = 4'd1,
    EV_BYTES   = 4'd2,
    EV_TEXT    = 4'd3,
    EV_ARRAY   = 4'd4,
    EV_MAP     = 4'd5,
    EV_TAG     = 4'd6,
    EV_SPECIAL = 4'd7,
    EV_PAYLOAD = 4'd8,
    EV_ERROR   = 4'd9
  } ev_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_RESERVED = 2'd1,
    ERR_LENGTH   = 2'd2
  } err_code_t;

  localparam logic [4:0] INFO_ARG1     = 5'd24;
  localparam logic [4:0] INFO_ARG8     = 5'd27;
  localparam logic [4:0] INFO_RESERVED = 5'd28;

  typedef struct packed {
    ev_kind_t    kind;
    logic [63:0] arg;
    logic [7:0]  pbyte;
    logic        last;
    err_code_t   err;
  } result_t;

endpackage

// ----- rtl/core/cbor_stream_decoder.sv -----
// cbor_stream_decoder: streaming CBOR item decoder, one stream byte per transfer.
// Depends on cbor_pkg, cbor_parse, cbor_outreg.
//
//   channel | ports                                        | dir
//   in      | in_valid, in_ready, in_stream_byte           | byte stream in
//   out     | out_valid, out_ready, out_event_kind,        | one event per
//           | out_argument_value, out_payload_byte,        | item header or
//           | out_payload_last, out_error_code             | payload byte
//
// One byte per cycle sustained while out_ready is high; a byte's event passes the input
// register, then parse logic into the result register, which drives out_valid.
// rst_n is synchronous; after reset the decoder expects a type byte.
// An error sticks until reset; bytes are then taken and dropped.
// A stalled out channel holds the input register, which then backs up in_ready.
module cbor_stream_decoder #(
  parameter int LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_stream_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_event_kind,
  output logic [63:0] out_argument_value,
  output logic [7:0]  out_payload_byte,
  output logic        out_payload_last,
  output logic [1:0]  out_error_code
);

  logic              in_valid_r;
  logic [7:0]        in_byte_r;
  logic              fire;
  logic              res_valid;
  logic              load_ready;
  cbor_pkg::result_t res;
  cbor_pkg::result_t out_data;

  assign fire     = in_valid_r && load_ready;
  assign in_ready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_stream_byte;
    end
  end

  cbor_parse #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (fire),
    .byte_i    (in_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  cbor_outreg u_outreg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire && res_valid),
    .load_data  (res),
    .load_ready (load_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign out_event_kind     = out_data.kind;
  assign out_argument_value = out_data.arg;
  assign out_payload_byte   = out_data.pbyte;
  assign out_payload_last   = out_data.last;
  assign out_error_code     = out_data.err;

endmodule

// ----- rtl/core/cbor_parse.sv -----
// cbor_parse: parser state and per-byte decode logic.
// Depends on cbor_pkg.
module cbor_parse #(
  parameter int LENGTH_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        byte_i,
  output logic              res_valid,
  output cbor_pkg::result_t res
);

  localparam logic [63:0] LEN_MASK = (LENGTH_BITS >= 64) ? {64{1'b1}} :
                                     ((64'd1 << LENGTH_BITS) - 64'd1);

  cbor_pkg::phase_t       phase_r, phase_nxt;
  logic [2:0]             major_r, major_nxt;
  logic [3:0]             arg_left_r, arg_left_nxt;
  logic [63:0]            acc_r, acc_nxt;
  logic [LENGTH_BITS-1:0] pay_left_r, pay_left_nxt;

  logic [2:0]  b_major;
  logic [4:0]  b_info;
  logic [3:0]  arg_left_dec;
  logic        fin;
  logic [2:0]  fin_major;
  logic [63:0] fin_arg;

  assign b_major = byte_i[7:5];
  assign b_info  = byte_i[4:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cbor_pkg::PH_TYPE;
    end else if (step) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      major_r    <= major_nxt;
      arg_left_r <= arg_left_nxt;
      acc_r      <= acc_nxt;
      pay_left_r <= pay_left_nxt;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    major_nxt    = major_r;
    arg_left_nxt = arg_left_r;
    acc_nxt      = acc_r;
    pay_left_nxt = pay_left_r;
    res_valid    = 1'b0;
    res          = '0;
    fin          = 1'b0;
    fin_major    = major_r;
    fin_arg      = acc_r;
    arg_left_dec = (arg_left_r != 4'd0) ? arg_left_r - 4'd1 : 4'd0;
    unique case (phase_r)
      cbor_pkg::PH_TYPE: begin
        if (b_info < cbor_pkg::INFO_ARG1) begin
          fin       = 1'b1;
          fin_major = b_major;
          fin_arg   = {59'd0, b_info};
        end else if (b_info >= cbor_pkg::INFO_RESERVED) begin
          phase_nxt = cbor_pkg::PH_ERROR;
          res_valid = 1'b1;
          res.kind  = cbor_pkg::EV_ERROR;
          res.err   = cbor_pkg::ERR_RESERVED;
        end else if (b_info == cbor_pkg::INFO_ARG8 &&
                     (b_major[2:1] == 2'b01 || b_major[2:1] == 2'b10)) begin
          phase_nxt = cbor_pkg::PH_ERROR;
          res_valid = 1'b1;
          res.kind  = cbor_pkg::EV_ERROR;
          res.err   = cbor_pkg::ERR_LENGTH;
        end else begin
          major_nxt    = b_major;
          arg_left_nxt = 4'd1 << b_info[1:0];
          acc_nxt      = '0;
          phase_nxt    = cbor_pkg::PH_ARG;
        end
      end
      cbor_pkg::PH_ARG: begin
        acc_nxt      = {acc_r[55:0], byte_i};
        arg_left_nxt = arg_left_dec;
        if (arg_left_dec == 4'd0) begin
          fin     = 1'b1;
          fin_arg = acc_nxt;
        end
      end
      cbor_pkg::PH_PAYLOAD: begin
        res_valid = 1'b1;
        res.kind  = cbor_pkg::EV_PAYLOAD;
        res.pbyte = byte_i;
        res.last  = (pay_left_r <= LENGTH_BITS'(1));
        if (pay_left_r != '0) begin
          pay_left_nxt = pay_left_r - LENGTH_BITS'(1);
        end
        if (res.last) begin
          phase_nxt = cbor_pkg::PH_TYPE;
        end
      end
      cbor_pkg::PH_ERROR: begin
      end
      default: begin
      end
    endcase

    if (fin) begin
      res_valid = 1'b1;
      if (fin_major[2:1] == 2'b01 && (fin_arg & ~LEN_MASK) != 64'd0) begin
        phase_nxt = cbor_pkg::PH_ERROR;
        res.kind  = cbor_pkg::EV_ERROR;
        res.err   = cbor_pkg::ERR_LENGTH;
      end else begin
        res.kind  = cbor_pkg::ev_kind_t'({1'b0, fin_major});
        res.arg   = fin_arg;
        phase_nxt = cbor_pkg::PH_TYPE;
        if (fin_major[2:1] == 2'b01) begin
          pay_left_nxt = fin_arg[LENGTH_BITS-1:0];
          if (fin_arg != 64'd0) begin
            phase_nxt = cbor_pkg::PH_PAYLOAD;
          end
        end
      end
    end
  end

  a_error_silent: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == cbor_pkg::PH_ERROR |-> !res_valid)
    else $error("result produced in error phase");

  a_error_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_valid && res.kind == cbor_pkg::EV_ERROR |=> phase_r == cbor_pkg::PH_ERROR)
    else $error("error event did not enter error phase");

  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == cbor_pkg::PH_PAYLOAD |-> pay_left_r != '0)
    else $error("payload phase with zero bytes left");

  a_arg_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == cbor_pkg::PH_ARG |-> arg_left_r != 4'd0 && arg_left_r <= 4'd8)
    else $error("argument byte count out of range");

endmodule

// ----- rtl/core/cbor_outreg.sv -----
// cbor_outreg: result register between the parser and the output channel.
// Depends on cbor_pkg.
module cbor_outreg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  cbor_pkg::result_t load_data,
  output logic              load_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output cbor_pkg::result_t out_data
);

  logic              valid_r, valid_nxt;
  cbor_pkg::result_t data_r;

  assign load_ready = !valid_r || out_ready;
  assign valid_nxt  = load ? 1'b1 : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> load_ready)
    else $error("result register overwritten while full");

endmodule

// ----- dv/tb_cbor_stream_decoder.sv -----
// tb_cbor_stream_decoder: self-checking testbench for the CBOR stream decoder.
// Depends on cbor_pkg and cbor_stream_decoder. Byte stream in, checks every event
// against a cycle-free decode model; ends on one sticky error, since reset comes once.
module tb_cbor_stream_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          LENGTH_BITS  = 32;
  localparam logic [63:0] LEN_MASK     = (64'd1 << LENGTH_BITS) - 64'd1;
  localparam int          IDLE_PCT     = 7;
  localparam int          STALL_LIMIT  = 1000;
  localparam int          TAIL_CYCLES  = 10;

  typedef enum int {ARG_IMM, ARG_1B, ARG_2B, ARG_4B, ARG_8B} arg_form_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_stream_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_event_kind;
  logic [63:0] out_argument_value;
  logic [7:0]  out_payload_byte;
  logic        out_payload_last;
  logic [1:0]  out_error_code;

  cbor_stream_decoder #(.LENGTH_BITS(LENGTH_BITS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_stream_byte(in_stream_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_event_kind(out_event_kind), .out_argument_value(out_argument_value),
    .out_payload_byte(out_payload_byte), .out_payload_last(out_payload_last),
    .out_error_code(out_error_code)
  );

  always #5 clk = ~clk;

  // decode model state
  cbor_pkg::phase_t dec_phase = cbor_pkg::PH_TYPE;
  logic [2:0]       dec_major = 3'd0;
  int               dec_arg_left = 0;
  logic [63:0]      dec_arg_acc = 64'd0;
  logic [63:0]      dec_pay_left = 64'd0;

  cbor_pkg::result_t expected_events[$];
  bit      steady = 1'b0;
  int      mismatches = 0;
  int      bytes_sent = 0;
  int      events_seen = 0;
  int      payload_seen = 0;
  int      error_seen = 0;
  int      quiet_cycles = 0;

  function automatic cbor_pkg::result_t make_event(cbor_pkg::ev_kind_t k, logic [63:0] a,
                                                   logic [7:0] pb, logic lst,
                                                   cbor_pkg::err_code_t e);
    cbor_pkg::result_t r;
    r.kind = k;
    r.arg = a;
    r.pbyte = pb;
    r.last = lst;
    r.err = e;
    return r;
  endfunction

  function automatic bit is_string(logic [2:0] major);
    return major == cbor_pkg::EV_BYTES[2:0] || major == cbor_pkg::EV_TEXT[2:0];
  endfunction

  function automatic void raise_decode_error(cbor_pkg::err_code_t code);
    dec_phase = cbor_pkg::PH_ERROR;
    expected_events.push_back(make_event(cbor_pkg::EV_ERROR, 64'd0, 8'd0, 1'b0, code));
  endfunction

  function automatic void complete_item(logic [2:0] major, logic [63:0] a);
    if (is_string(major)) begin
      if (a > LEN_MASK) begin
        raise_decode_error(cbor_pkg::ERR_LENGTH);
        return;
      end
      dec_pay_left = a;
      dec_phase = (a != 64'd0) ? cbor_pkg::PH_PAYLOAD : cbor_pkg::PH_TYPE;
    end else begin
      dec_phase = cbor_pkg::PH_TYPE;
    end
    expected_events.push_back(make_event(cbor_pkg::ev_kind_t'({1'b0, major}), a, 8'd0,
                                         1'b0, cbor_pkg::ERR_NONE));
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    logic [2:0] major;
    logic [4:0] info;
    logic       lst;
    major = b[7:5];
    info = b[4:0];
    case (dec_phase)
      cbor_pkg::PH_TYPE: begin
        if (info < cbor_pkg::INFO_ARG1) begin
          complete_item(major, {59'd0, info});
        end else if (info >= cbor_pkg::INFO_RESERVED) begin
          raise_decode_error(cbor_pkg::ERR_RESERVED);
        end else if (info == cbor_pkg::INFO_ARG8 &&
                     (is_string(major) || major == cbor_pkg::EV_ARRAY[2:0] ||
                      major == cbor_pkg::EV_MAP[2:0])) begin
          raise_decode_error(cbor_pkg::ERR_LENGTH);
        end else begin
          dec_major = major;
          dec_arg_left = 1 << (info - cbor_pkg::INFO_ARG1);
          dec_arg_acc = 64'd0;
          dec_phase = cbor_pkg::PH_ARG;
        end
      end
      cbor_pkg::PH_ARG: begin
        dec_arg_acc = {dec_arg_acc[55:0], b};
        dec_arg_left--;
        if (dec_arg_left == 0) complete_item(dec_major, dec_arg_acc);
      end
      cbor_pkg::PH_PAYLOAD: begin
        lst = (dec_pay_left <= 64'd1);
        if (dec_pay_left != 64'd0) dec_pay_left--;
        if (lst) dec_phase = cbor_pkg::PH_TYPE;
        expected_events.push_back(make_event(cbor_pkg::EV_PAYLOAD, 64'd0, b, lst,
                                             cbor_pkg::ERR_NONE));
      end
      default: ;
    endcase
  endfunction

  task automatic send_byte(logic [7:0] b);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_stream_byte <= b;
    do @(posedge clk); while (!in_ready);
    decode_byte(b);
    bytes_sent++;
  endtask

  task automatic send_head(logic [2:0] major, arg_form_t form, logic [63:0] a);
    logic [4:0] info;
    int n;
    case (form)
      ARG_IMM: begin info = a[4:0]; n = 0; end
      ARG_1B:  begin info = cbor_pkg::INFO_ARG1; n = 1; end
      ARG_2B:  begin info = cbor_pkg::INFO_ARG1 + 5'd1; n = 2; end
      ARG_4B:  begin info = cbor_pkg::INFO_ARG1 + 5'd2; n = 4; end
      default: begin info = cbor_pkg::INFO_ARG8; n = 8; end
    endcase
    send_byte({major, info});
    for (int i = n - 1; i >= 0; i--) send_byte(a[8*i +: 8]);
  endtask

  task automatic send_string(logic [2:0] major, arg_form_t form, int len);
    send_head(major, form, 64'(len));
    repeat (len) send_byte(8'($urandom));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
  endtask

  // well-formed item with random content; never one that trips an error
  task automatic send_random_item();
    logic [2:0]  major;
    arg_form_t   form;
    logic [63:0] a;
    int          len;
    major = 3'($urandom_range(7));
    if (is_string(major)) begin
      form = arg_form_t'($urandom_range(ARG_4B));
      case (form)
        ARG_IMM: len = $urandom_range(23);
        ARG_1B:  len = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(40);
        ARG_2B:  len = ($urandom_range(19) == 0) ? $urandom_range(300) : $urandom_range(20);
        default: len = $urandom_range(12);
      endcase
      send_string(major, form, len);
    end else begin
      if (major == cbor_pkg::EV_ARRAY[2:0] || major == cbor_pkg::EV_MAP[2:0])
        form = arg_form_t'($urandom_range(ARG_4B));
      else
        form = arg_form_t'($urandom_range(ARG_8B));
      a = {$urandom, $urandom};
      case (form)
        ARG_IMM: a = 64'($urandom_range(23));
        ARG_1B:  a = {56'd0, a[7:0]};
        ARG_2B:  a = {48'd0, a[15:0]};
        ARG_4B:  a = {32'd0, a[31:0]};
        default: ;
      endcase
      send_head(major, form, a);
    end
  endtask

  task automatic test_directed_items();
    send_head(cbor_pkg::EV_UINT[2:0], ARG_IMM, 64'd0);
    send_head(cbor_pkg::EV_UINT[2:0], ARG_IMM, 64'd23);
    send_head(cbor_pkg::EV_UINT[2:0], ARG_1B, 64'd5);
    send_head(cbor_pkg::EV_UINT[2:0], ARG_1B, 64'hFF);
    send_head(cbor_pkg::EV_UINT[2:0], ARG_2B, 64'hFFFF);
    send_head(cbor_pkg::EV_UINT[2:0], ARG_4B, 64'hFFFF_FFFF);
    send_head(cbor_pkg::EV_UINT[2:0], ARG_8B, '1);
    send_head(cbor_pkg::EV_UINT[2:0], ARG_8B, 64'd0);
    send_head(cbor_pkg::EV_NEGINT[2:0], ARG_IMM, 64'd0);
    send_head(cbor_pkg::EV_NEGINT[2:0], ARG_8B, 64'h8000_0000_0000_0001);
    send_string(cbor_pkg::EV_BYTES[2:0], ARG_IMM, 0);
    send_head(cbor_pkg::EV_BYTES[2:0], ARG_IMM, 64'd2);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_string(cbor_pkg::EV_TEXT[2:0], ARG_2B, 3);
    send_string(cbor_pkg::EV_TEXT[2:0], ARG_4B, 0);
    send_string(cbor_pkg::EV_BYTES[2:0], ARG_1B, 1);
    send_head(cbor_pkg::EV_ARRAY[2:0], ARG_IMM, 64'd23);
    send_head(cbor_pkg::EV_ARRAY[2:0], ARG_4B, 64'h8000_0000);
    send_head(cbor_pkg::EV_MAP[2:0], ARG_1B, 64'd200);
    send_head(cbor_pkg::EV_TAG[2:0], ARG_2B, 64'hA5A5);
    send_head(cbor_pkg::EV_SPECIAL[2:0], ARG_IMM, 64'd20);
    send_head(cbor_pkg::EV_SPECIAL[2:0], ARG_IMM, 64'd23);
    send_head(cbor_pkg::EV_SPECIAL[2:0], ARG_1B, 64'hFF);
    send_head(cbor_pkg::EV_SPECIAL[2:0], ARG_8B, 64'h7FF0_0000_0000_0001);
  endtask

  task automatic test_random_stream(int n_bytes);
    int start;
    int next_pause;
    start = bytes_sent;
    next_pause = bytes_sent + 300;
    while (bytes_sent - start < n_bytes) begin
      send_random_item();
      if (bytes_sent >= next_pause) begin
        wait_drained();
        next_pause = bytes_sent + 300;
      end
    end
  endtask

  task automatic test_back_to_back(int n_bytes);
    steady = 1'b1;
    test_random_stream(n_bytes);
    steady = 1'b0;
  endtask

  // one sticky error, then bytes that must be dropped without any event
  task automatic test_sticky_error();
    logic [2:0] major;
    logic [4:0] info;
    if ($urandom_range(1)) begin
      major = 3'($urandom_range(7));
      info = 5'($urandom_range(cbor_pkg::INFO_RESERVED, 31));
    end else begin
      major = 3'($urandom_range(cbor_pkg::EV_BYTES, cbor_pkg::EV_MAP));
      info = cbor_pkg::INFO_ARG8;
    end
    send_byte({major, info});
    repeat (40) send_byte(8'($urandom));
  endtask

  always @(posedge clk) begin
    cbor_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      events_seen++;
      if (expected_events.size() == 0) begin
        $error("unexpected event: kind %0d arg %0h", out_event_kind, out_argument_value);
        mismatches++;
      end else begin
        want = expected_events.pop_front();
        if (out_event_kind == cbor_pkg::EV_PAYLOAD) payload_seen++;
        if (out_event_kind == cbor_pkg::EV_ERROR) error_seen = out_error_code;
        if (out_event_kind !== want.kind) begin
          $error("event_kind: expected %0d, got %0d", want.kind, out_event_kind);
          mismatches++;
        end
        if (out_argument_value !== want.arg) begin
          $error("argument_value: expected %0h, got %0h", want.arg, out_argument_value);
          mismatches++;
        end
        if (out_payload_byte !== want.pbyte) begin
          $error("payload_byte: expected %0h, got %0h", want.pbyte, out_payload_byte);
          mismatches++;
        end
        if (out_payload_last !== want.last) begin
          $error("payload_last: expected %0d, got %0d", want.last, out_payload_last);
          mismatches++;
        end
        if (out_error_code !== want.err) begin
          $error("error_code: expected %0d, got %0d", want.err, out_error_code);
          mismatches++;
        end
      end
    end
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_items();
    test_random_stream(600);
    test_back_to_back(250);
    test_random_stream(400);
    test_sticky_error();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d stream bytes; checked %0d events, %0d of them payload bytes.",
             bytes_sent, events_seen, payload_seen);
    $display("Run closed on a sticky error with code %0d and dropped bytes after it.",
             error_seen);
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/cbor_pkg.sv
rtl/core/cbor_parse.sv
rtl/core/cbor_outreg.sv
rtl/core/cbor_stream_decoder.sv
dv/tb_cbor_stream_decoder.sv
